// File: rtl/core/even_step_sequence_distributor_top_macros.svh
// Assertion macros shared by the distributor RTL.
`ifndef EVEN_STEP_SEQUENCE_DISTRIBUTOR_TOP_MACROS_SVH
`define EVEN_STEP_SEQUENCE_DISTRIBUTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ESD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ESD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/esd_pkg.sv
// Shared widths, types and state codes for the step distributor.
`default_nettype none

package esd_pkg;

    localparam int unsigned VAL_W   = 10;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned TGT_W   = 18;
    localparam int unsigned SLOT_W  = 6;
    localparam int unsigned MUL_X_W = 18;
    localparam int unsigned MUL_Y_W = 8;
    localparam int unsigned PROD_W  = MUL_X_W + MUL_Y_W;
    // signed error term, covers T*n - 256*S and the B-minus-A shift
    localparam int unsigned D_W     = 30;

    typedef struct packed {
        logic [VAL_W-1:0]  step_value;
        logic [SLOT_W-1:0] slot;
        logic              last;
        logic              bad_request;
    } t_result;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MT   = 7'b0000010,
        S_MA   = 7'b0000100,
        S_MB   = 7'b0001000,
        S_SUB  = 7'b0010000,
        S_DEC  = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/esd_mul.sv
// Shared registered unsigned multiplier used by the sequencer.
`default_nettype none

module esd_mul (
    input  wire logic                         i_clk,
    input  wire logic [esd_pkg::MUL_X_W-1:0]  i_x,
    input  wire logic [esd_pkg::MUL_Y_W-1:0]  i_y,
    output logic      [esd_pkg::PROD_W-1:0]   o_prod
);

    logic [esd_pkg::PROD_W-1:0] r_prod;

    // one product per cycle, registered result
    always_ff @(posedge i_clk) begin
        r_prod <= esd_pkg::PROD_W'(i_x) * esd_pkg::PROD_W'(i_y);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: rtl/core/esd_seq.sv
// Sequencer: walks the slots, drives the shared multiplier, picks A or B.
`default_nettype none
`include "even_step_sequence_distributor_top_macros.svh"

module esd_seq #(
    parameter int unsigned MAX_SLOTS = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request side
    input  wire logic                        i_req_valid,
    output logic                             o_req_ready,
    input  wire logic [esd_pkg::VAL_W-1:0]   i_value_a,
    input  wire logic [esd_pkg::VAL_W-1:0]   i_value_b,
    input  wire logic [esd_pkg::CNT_W-1:0]   i_count_a,
    input  wire logic [esd_pkg::CNT_W-1:0]   i_count_b,
    input  wire logic [esd_pkg::TGT_W-1:0]   i_target_average,
    input  wire logic [esd_pkg::SLOT_W-1:0]  i_start_slot,
    // result side
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output esd_pkg::t_result                 o_res
);

    localparam logic [esd_pkg::SLOT_W-1:0] SLOT_MAX = esd_pkg::SLOT_W'(MAX_SLOTS - 1);

    esd_pkg::t_state r_state, n_state;

    logic [esd_pkg::VAL_W-1:0]  r_a, n_a;
    logic [esd_pkg::VAL_W-1:0]  r_b, n_b;
    logic [esd_pkg::CNT_W-1:0]  r_left_a, n_left_a;
    logic [esd_pkg::CNT_W-1:0]  r_left_b, n_left_b;
    logic [esd_pkg::TGT_W-1:0]  r_target, n_target;
    logic [esd_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic                       r_bad, n_bad;
    logic                       r_pick_b, n_pick_b;
    logic signed [esd_pkg::D_W-1:0] r_d, n_d;

    logic [esd_pkg::MUL_X_W-1:0] mul_x;
    logic [esd_pkg::MUL_Y_W-1:0] mul_y;
    logic [esd_pkg::PROD_W-1:0]  mul_prod;

    logic [esd_pkg::MUL_Y_W-1:0]     n_total;
    logic signed [esd_pkg::VAL_W:0]  diff_ba;
    logic signed [esd_pkg::D_W-1:0]  delta;
    logic signed [esd_pkg::D_W-1:0]  alt_d;
    logic [esd_pkg::D_W-1:0]         mag_b;
    logic [esd_pkg::D_W-1:0]         mag_a;
    logic                            both_left;
    logic [esd_pkg::CNT_W-1:0]       nx_left_a;
    logic [esd_pkg::CNT_W-1:0]       nx_left_b;

    esd_mul u_mul (
        .i_clk  (i_clk),
        .i_x    (mul_x),
        .i_y    (mul_y),
        .o_prod (mul_prod)
    );

    // remaining entries after this slot: left_a + left_b - 1
    assign n_total = esd_pkg::MUL_Y_W'({1'b0, r_left_a}) + esd_pkg::MUL_Y_W'({1'b0, r_left_b})
                     - esd_pkg::MUL_Y_W'(1);

    // operand select for the shared multiplier
    always_comb begin
        mul_x = '0;
        mul_y = '0;
        unique case (r_state)
            esd_pkg::S_MT: begin
                mul_x = r_target;
                mul_y = n_total;
            end
            esd_pkg::S_MA: begin
                mul_x = esd_pkg::MUL_X_W'(r_a);
                mul_y = esd_pkg::MUL_Y_W'(r_left_a);
            end
            esd_pkg::S_MB: begin
                mul_x = esd_pkg::MUL_X_W'(r_b);
                mul_y = esd_pkg::MUL_Y_W'(r_left_b) - esd_pkg::MUL_Y_W'(1);
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    // |d| against |d - 256*(b - a)|: B wins ties
    assign diff_ba = $signed({1'b0, r_b}) - $signed({1'b0, r_a});
    assign delta   = esd_pkg::D_W'(diff_ba) <<< 8;
    assign alt_d   = r_d - delta;
    assign mag_b   = r_d[esd_pkg::D_W-1]   ? esd_pkg::D_W'(-r_d)   : esd_pkg::D_W'(r_d);
    assign mag_a   = alt_d[esd_pkg::D_W-1] ? esd_pkg::D_W'(-alt_d) : esd_pkg::D_W'(alt_d);

    // counts after this slot is placed
    assign both_left = (r_left_a != '0) && (r_left_b != '0);
    assign nx_left_a = (both_left && !r_pick_b) ? r_left_a - 1'b1 : r_left_a;
    assign nx_left_b = (both_left &&  r_pick_b) ? r_left_b - 1'b1 : r_left_b;

    // result beat
    always_comb begin
        o_res.slot        = r_slot;
        o_res.bad_request = r_bad;
        o_res.last        = r_bad || (r_slot == '0);
        if (r_bad) begin
            o_res.step_value = '0;
        end else if (r_left_a == '0) begin
            o_res.step_value = r_b;
        end else if (r_left_b == '0) begin
            o_res.step_value = r_a;
        end else if (r_pick_b) begin
            o_res.step_value = r_b;
        end else begin
            o_res.step_value = r_a;
        end
    end

    assign o_res_valid = (r_state == esd_pkg::S_EMIT);
    assign o_req_ready = (r_state == esd_pkg::S_IDLE);

    // sequencer next state
    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_left_a = r_left_a;
        n_left_b = r_left_b;
        n_target = r_target;
        n_slot   = r_slot;
        n_bad    = r_bad;
        n_pick_b = r_pick_b;
        n_d      = r_d;
        unique case (r_state)
            esd_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_a      = i_value_a;
                    n_b      = i_value_b;
                    n_left_a = i_count_a;
                    n_left_b = i_count_b;
                    n_target = i_target_average;
                    n_slot   = (i_start_slot > SLOT_MAX) ? SLOT_MAX : i_start_slot;
                    n_bad    = (i_count_a == '0) && (i_count_b == '0);
                    n_pick_b = 1'b0;
                    if ((i_count_a == '0) || (i_count_b == '0)) begin
                        n_state = esd_pkg::S_EMIT;
                    end else begin
                        n_state = esd_pkg::S_MT;
                    end
                end
            end
            esd_pkg::S_MT: begin
                n_state = esd_pkg::S_MA;
            end
            esd_pkg::S_MA: begin
                // T * n arrives
                n_d     = esd_pkg::D_W'(mul_prod);
                n_state = esd_pkg::S_MB;
            end
            esd_pkg::S_MB: begin
                // left_a * a arrives
                n_d     = r_d - esd_pkg::D_W'({mul_prod, 8'b0});
                n_state = esd_pkg::S_SUB;
            end
            esd_pkg::S_SUB: begin
                // (left_b - 1) * b arrives
                n_d     = r_d - esd_pkg::D_W'({mul_prod, 8'b0});
                n_state = esd_pkg::S_DEC;
            end
            esd_pkg::S_DEC: begin
                n_pick_b = (mag_b <= mag_a);
                n_state  = esd_pkg::S_EMIT;
            end
            esd_pkg::S_EMIT: begin
                if (i_res_ready) begin
                    n_left_a = nx_left_a;
                    n_left_b = nx_left_b;
                    if (r_bad || (r_slot == '0)) begin
                        n_state = esd_pkg::S_IDLE;
                    end else begin
                        n_slot = r_slot - 1'b1;
                        if ((nx_left_a == '0) || (nx_left_b == '0)) begin
                            n_state = esd_pkg::S_EMIT;
                        end else begin
                            n_state = esd_pkg::S_MT;
                        end
                    end
                end
            end
            default: begin
                n_state = esd_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= esd_pkg::S_IDLE;
            r_left_a <= '0;
            r_left_b <= '0;
            r_slot   <= '0;
            r_bad    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_left_a <= n_left_a;
            r_left_b <= n_left_b;
            r_slot   <= n_slot;
            r_bad    <= n_bad;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_target <= n_target;
        r_pick_b <= n_pick_b;
        r_d      <= n_d;
    end

    `ESD_ASSERT_IMP(a_bad_single, i_clk, i_rst_n, o_res_valid && o_res.bad_request, o_res.last && (o_res.step_value == '0), "bad request beat must be last with zero value")
    `ESD_ASSERT_IMP(a_last_at_zero, i_clk, i_rst_n, o_res_valid && o_res.last && !o_res.bad_request, o_res.slot == '0, "normal run ended away from slot zero")
    `ESD_ASSERT_NXT(a_slot_down, i_clk, i_rst_n, o_res_valid && i_res_ready && !o_res.last, r_slot == ($past(r_slot) - 1'b1), "slot did not step down by one")

endmodule

`default_nettype wire

// File: rtl/core/even_step_sequence_distributor_top.sv
// Flow: an accepted request goes straight to the emit state when one count is zero,
// else through the MT, MA, MB, SUB and DEC states; each emitted beat is registered.
// Each later slot passes MT, MA, MB, SUB and DEC again while both counts are nonzero
// (three shared multiplier products, then the compare), else it is emitted directly.
// One request is worked at a time; ready is high only between runs.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and empties the output.
`default_nettype none

module even_step_sequence_distributor_top #(
    parameter int unsigned MAX_SLOTS = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [esd_pkg::VAL_W-1:0]   i_value_a,
    input  wire logic [esd_pkg::VAL_W-1:0]   i_value_b,
    input  wire logic [esd_pkg::CNT_W-1:0]   i_count_a,
    input  wire logic [esd_pkg::CNT_W-1:0]   i_count_b,
    input  wire logic [esd_pkg::TGT_W-1:0]   i_target_average,
    input  wire logic [esd_pkg::SLOT_W-1:0]  i_start_slot,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [esd_pkg::VAL_W-1:0]        o_step_value,
    output logic [esd_pkg::SLOT_W-1:0]       o_slot,
    output logic                             o_last,
    output logic                             o_bad_request
);

    logic             res_valid;
    logic             res_ready;
    esd_pkg::t_result res;

    logic             r_out_valid;
    esd_pkg::t_result r_out;

    esd_seq #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_in_valid),
        .o_req_ready      (o_in_ready),
        .i_value_a        (i_value_a),
        .i_value_b        (i_value_b),
        .i_count_a        (i_count_a),
        .i_count_b        (i_count_b),
        .i_target_average (i_target_average),
        .i_start_slot     (i_start_slot),
        .o_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .o_res            (res)
    );

    // output register takes a beat when empty or draining
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_step_value  = r_out.step_value;
    assign o_slot        = r_out.slot;
    assign o_last        = r_out.last;
    assign o_bad_request = r_out.bad_request;

endmodule

`default_nettype wire
